// ----- rtl/core/rcspt_pkg.sv -----
package rcspt_pkg;

  // default configuration
  localparam int unsigned SLOT_COUNT_DEF = 64;
  localparam int unsigned PAGE_BYTES_DEF = 4096;
  localparam int unsigned FRAME_BITS_DEF = 20;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int unsigned ID_W    = 32;
  localparam int unsigned PSIZE_W = 31;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned SLOT_W  = 6;

  typedef enum logic {
    OP_OPEN  = 1'b0,
    OP_CLOSE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_NOFRAME = 3'd2,
    ST_NOTOPEN = 3'd3,
    ST_BADID   = 3'd4,
    ST_CNTFULL = 3'd5
  } status_e;

  // slot memory port controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // result flags from the sequencer
  typedef struct packed {
    status_e status;
    logic    is_open;
    logic    taken;
    logic    freed;
  } res_ctl_t;

endpackage

// ----- rtl/core/rcspt_req_if.sv -----
interface rcspt_req_if #(
  parameter int unsigned FRAME_BITS = rcspt_pkg::FRAME_BITS_DEF
) ();
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [rcspt_pkg::ID_W-1:0]       region_id;
  logic [FRAME_BITS-1:0]            offered_frame;
  logic                             offered_valid;
  logic [rcspt_pkg::PSIZE_W-1:0]    process_size;

  modport source (
    output valid, op, region_id, offered_frame, offered_valid, process_size,
    input  ready
  );
  modport sink (
    input  valid, op, region_id, offered_frame, offered_valid, process_size,
    output ready
  );
endinterface

// ----- rtl/core/rcspt_rsp_if.sv -----
interface rcspt_rsp_if #(
  parameter int unsigned FRAME_BITS = rcspt_pkg::FRAME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rcspt_pkg::COUNT_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [rcspt_pkg::SLOT_W-1:0]  slot_index;
  logic [FRAME_BITS-1:0]         region_frame;
  logic                          frame_taken;
  logic [rcspt_pkg::ADDR_W-1:0]  map_address;
  logic [rcspt_pkg::ADDR_W-1:0]  new_process_size;
  logic [COUNT_BITS-1:0]         ref_count;
  logic                          slot_freed;

  modport source (
    output valid, status, slot_index, region_frame, frame_taken, map_address,
           new_process_size, ref_count, slot_freed,
    input  ready
  );
  modport sink (
    input  valid, status, slot_index, region_frame, frame_taken, map_address,
           new_process_size, ref_count, slot_freed,
    output ready
  );
endinterface

// ----- rtl/core/rcspt_slot_mem.sv -----
module rcspt_slot_mem #(
  parameter int unsigned SLOT_COUNT = rcspt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned FRAME_BITS = rcspt_pkg::FRAME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rcspt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rcspt_pkg::mem_ctl_t           ctl_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] raddr_i,
  input  logic [$clog2(SLOT_COUNT)-1:0] waddr_i,
  input  logic [rcspt_pkg::ID_W-1:0]    wkey_i,
  input  logic [FRAME_BITS-1:0]         wframe_i,
  input  logic [COUNT_BITS-1:0]         wcount_i,
  output logic [rcspt_pkg::ID_W-1:0]    rkey_o,
  output logic [FRAME_BITS-1:0]         rframe_o,
  output logic [COUNT_BITS-1:0]         rcount_o
);

  localparam int unsigned EntryW = rcspt_pkg::ID_W + FRAME_BITS + COUNT_BITS;

  logic [EntryW-1:0]     mem_q [SLOT_COUNT];
  logic [EntryW-1:0]     rdata_q;
  logic [SLOT_COUNT-1:0] valid_q;
  logic                  rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[waddr_i] <= {wkey_i, wframe_i, wcount_i};
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // written-once flags: an entry never written reads as a free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  always_comb begin
    if (rvalid_q) begin
      {rkey_o, rframe_o, rcount_o} = rdata_q;
    end else begin
      {rkey_o, rframe_o, rcount_o} = '0;
    end
  end

endmodule

// ----- rtl/core/rcspt_ctrl.sv -----
module rcspt_ctrl #(
  parameter int unsigned SLOT_COUNT = rcspt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned FRAME_BITS = rcspt_pkg::FRAME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rcspt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          op_i,
  input  logic [rcspt_pkg::ID_W-1:0]    id_i,
  input  logic [FRAME_BITS-1:0]         offer_i,
  input  logic                          offer_ok_i,
  output logic                          busy_o,
  output rcspt_pkg::mem_ctl_t           mem_ctl_o,
  output logic [$clog2(SLOT_COUNT)-1:0] mem_raddr_o,
  output logic [$clog2(SLOT_COUNT)-1:0] mem_waddr_o,
  output logic [rcspt_pkg::ID_W-1:0]    mem_wkey_o,
  output logic [FRAME_BITS-1:0]         mem_wframe_o,
  output logic [COUNT_BITS-1:0]         mem_wcount_o,
  input  logic [rcspt_pkg::ID_W-1:0]    mem_rkey_i,
  input  logic [FRAME_BITS-1:0]         mem_rframe_i,
  input  logic [COUNT_BITS-1:0]         mem_rcount_i,
  input  logic                          res_space_i,
  output logic                          res_load_o,
  output rcspt_pkg::res_ctl_t           res_ctl_o,
  output logic [$clog2(SLOT_COUNT)-1:0] res_slot_o,
  output logic [FRAME_BITS-1:0]         res_frame_o,
  output logic [COUNT_BITS-1:0]         res_count_o
);

  localparam int unsigned IdxW = $clog2(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC
  } state_e;

  state_e                       state_q;
  logic                         op_q;
  logic [rcspt_pkg::ID_W-1:0]   id_q;
  logic [FRAME_BITS-1:0]        offer_q;
  logic                         offer_ok_q;
  logic                         badid_q;
  logic [IdxW:0]                rd_cnt_q;
  logic                         chk_v_q;
  logic [IdxW-1:0]              chk_idx_q;
  logic                         hit_q;
  logic [IdxW-1:0]              hit_idx_q;
  logic [FRAME_BITS-1:0]        hit_frame_q;
  logic [COUNT_BITS-1:0]        hit_count_q;
  logic                         free_v_q;
  logic [IdxW-1:0]              free_idx_q;

  logic                         issue;
  logic                         key_match;
  logic                         wr_ok;
  logic [COUNT_BITS-1:0]        dec_count;

  assign busy_o      = (state_q != S_IDLE);
  assign issue       = (state_q == S_SCAN) && (rd_cnt_q < (IdxW + 1)'(SLOT_COUNT));
  assign mem_raddr_o = rd_cnt_q[IdxW-1:0];
  // the one shared comparator, one slot per cycle
  assign key_match   = (mem_rkey_i == id_q);
  assign dec_count   = hit_count_q - COUNT_BITS'(1);

  // decision once the scan is over
  always_comb begin
    res_ctl_o.status  = rcspt_pkg::ST_OK;
    res_ctl_o.is_open = (op_q == rcspt_pkg::OP_OPEN);
    res_ctl_o.taken   = 1'b0;
    res_ctl_o.freed   = 1'b0;
    res_slot_o        = '0;
    res_frame_o       = '0;
    res_count_o       = '0;
    wr_ok             = 1'b0;
    mem_waddr_o       = hit_idx_q;
    mem_wkey_o        = id_q;
    mem_wframe_o      = hit_frame_q;
    mem_wcount_o      = hit_count_q;
    if (badid_q) begin
      res_ctl_o.status = rcspt_pkg::ST_BADID;
    end else if (op_q == rcspt_pkg::OP_OPEN) begin
      if (hit_q) begin
        if (hit_count_q == '1) begin
          res_ctl_o.status = rcspt_pkg::ST_CNTFULL;
        end else begin
          wr_ok        = 1'b1;
          mem_wcount_o = hit_count_q + COUNT_BITS'(1);
          res_slot_o   = hit_idx_q;
          res_frame_o  = hit_frame_q;
          res_count_o  = mem_wcount_o;
        end
      end else if (!free_v_q) begin
        res_ctl_o.status = rcspt_pkg::ST_FULL;
      end else if (!offer_ok_q) begin
        res_ctl_o.status = rcspt_pkg::ST_NOFRAME;
      end else begin
        wr_ok           = 1'b1;
        mem_waddr_o     = free_idx_q;
        mem_wframe_o    = offer_q;
        mem_wcount_o    = COUNT_BITS'(1);
        res_ctl_o.taken = 1'b1;
        res_slot_o      = free_idx_q;
        res_frame_o     = offer_q;
        res_count_o     = COUNT_BITS'(1);
      end
    end else begin
      if (!hit_q || hit_count_q == '0) begin
        res_ctl_o.status = rcspt_pkg::ST_NOTOPEN;
      end else begin
        wr_ok        = 1'b1;
        mem_wcount_o = dec_count;
        res_slot_o   = hit_idx_q;
        res_frame_o  = hit_frame_q;
        res_count_o  = dec_count;
        if (dec_count == '0) begin
          mem_wkey_o      = '0;
          mem_wframe_o    = '0;
          res_ctl_o.freed = 1'b1;
        end
      end
    end
  end

  assign res_load_o      = (state_q == S_EXEC) && res_space_i;
  assign mem_ctl_o.rd_en = issue;
  assign mem_ctl_o.wr_en = res_load_o && wr_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= 1'b0;
      id_q        <= '0;
      offer_q     <= '0;
      offer_ok_q  <= 1'b0;
      badid_q     <= 1'b0;
      rd_cnt_q    <= '0;
      chk_v_q     <= 1'b0;
      chk_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      hit_frame_q <= '0;
      hit_count_q <= '0;
      free_v_q    <= 1'b0;
      free_idx_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q       <= op_i;
            id_q       <= id_i;
            offer_q    <= offer_i;
            offer_ok_q <= offer_ok_i;
            badid_q    <= (id_i == '0);
            rd_cnt_q   <= '0;
            chk_v_q    <= 1'b0;
            hit_q      <= 1'b0;
            free_v_q   <= 1'b0;
            state_q    <= (id_i == '0) ? S_EXEC : S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + (IdxW + 1)'(1);
          end
          chk_v_q   <= issue;
          chk_idx_q <= rd_cnt_q[IdxW-1:0];
          if (chk_v_q) begin
            if (key_match) begin
              // first slot holding the id wins
              hit_q       <= 1'b1;
              hit_idx_q   <= chk_idx_q;
              hit_frame_q <= mem_rframe_i;
              hit_count_q <= mem_rcount_i;
              state_q     <= S_EXEC;
            end else begin
              if (mem_rkey_i == '0 && !free_v_q) begin
                free_v_q   <= 1'b1;
                free_idx_q <= chk_idx_q;
              end
              if (chk_idx_q == IdxW'(SLOT_COUNT - 1)) begin
                state_q <= S_EXEC;
              end
            end
          end
        end
        S_EXEC: begin
          if (res_space_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/refcounted_shared_page_table.sv -----
// Reference-counted shared-page table. SLOT_COUNT slots each hold a region id, a
// frame number and a reference count, all free after reset. An open bumps the count
// of the slot holding the id, or else claims the lowest free slot with the offered
// frame and a count of one; it returns the frame, the process size rounded up to a
// page as the map address, and that address plus one page. A close drops the count
// and frees the slot at zero. Errors (bad id, table full, no frame, not open, count
// full) give all-zero fields and leave the table alone. One request item is worked
// at a time: the slot memory is read one slot per cycle by a single comparator, and
// a hit ends the scan early. The result sits in an output register, so the next item
// is accepted while it waits. PAGE_BYTES must be a power of two.
module refcounted_shared_page_table #(
  parameter int unsigned SLOT_COUNT = rcspt_pkg::SLOT_COUNT_DEF,
  parameter int unsigned PAGE_BYTES = rcspt_pkg::PAGE_BYTES_DEF,
  parameter int unsigned FRAME_BITS = rcspt_pkg::FRAME_BITS_DEF,
  parameter int unsigned COUNT_BITS = rcspt_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rcspt_req_if.sink   req_i,
  rcspt_rsp_if.source rsp_o
);

  localparam int unsigned IdxW  = $clog2(SLOT_COUNT);
  localparam int unsigned PageW = $clog2(PAGE_BYTES);
  localparam int unsigned AW    = rcspt_pkg::ADDR_W;

  // sequencer <-> slot memory
  rcspt_pkg::mem_ctl_t       mem_ctl;
  logic [IdxW-1:0]           mem_raddr;
  logic [IdxW-1:0]           mem_waddr;
  logic [rcspt_pkg::ID_W-1:0] mem_wkey;
  logic [FRAME_BITS-1:0]     mem_wframe;
  logic [COUNT_BITS-1:0]     mem_wcount;
  logic [rcspt_pkg::ID_W-1:0] mem_rkey;
  logic [FRAME_BITS-1:0]     mem_rframe;
  logic [COUNT_BITS-1:0]     mem_rcount;

  // sequencer -> output register
  logic                      busy;
  logic                      accept;
  logic                      res_space;
  logic                      res_load;
  rcspt_pkg::res_ctl_t       res_ctl;
  logic [IdxW-1:0]           res_slot;
  logic [FRAME_BITS-1:0]     res_frame;
  logic [COUNT_BITS-1:0]     res_count;

  // process size is held here for the map address
  logic [rcspt_pkg::PSIZE_W-1:0] psize_q;
  logic [AW-1:0]                 round_sum;
  logic [AW-1:0]                 map_addr;
  logic [IdxW+rcspt_pkg::SLOT_W-1:0] slot_ext;

  // output register
  logic                          out_v_q;
  rcspt_pkg::status_e            status_q;
  logic [rcspt_pkg::SLOT_W-1:0]  slot_q;
  logic [FRAME_BITS-1:0]         frame_q;
  logic                          taken_q;
  logic [AW-1:0]                 map_q;
  logic [AW-1:0]                 nsize_q;
  logic [COUNT_BITS-1:0]         count_q;
  logic                          freed_q;

  assign req_i.ready = !busy;
  assign accept      = req_i.valid && !busy;
  // the output register frees up in the cycle its item is taken
  assign res_space   = !out_v_q || rsp_o.ready;

  rcspt_slot_mem #(
    .SLOT_COUNT (SLOT_COUNT),
    .FRAME_BITS (FRAME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_slot_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mem_ctl),
    .raddr_i  (mem_raddr),
    .waddr_i  (mem_waddr),
    .wkey_i   (mem_wkey),
    .wframe_i (mem_wframe),
    .wcount_i (mem_wcount),
    .rkey_o   (mem_rkey),
    .rframe_o (mem_rframe),
    .rcount_o (mem_rcount)
  );

  rcspt_ctrl #(
    .SLOT_COUNT (SLOT_COUNT),
    .FRAME_BITS (FRAME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (accept),
    .op_i         (req_i.op),
    .id_i         (req_i.region_id),
    .offer_i      (req_i.offered_frame),
    .offer_ok_i   (req_i.offered_valid),
    .busy_o       (busy),
    .mem_ctl_o    (mem_ctl),
    .mem_raddr_o  (mem_raddr),
    .mem_waddr_o  (mem_waddr),
    .mem_wkey_o   (mem_wkey),
    .mem_wframe_o (mem_wframe),
    .mem_wcount_o (mem_wcount),
    .mem_rkey_i   (mem_rkey),
    .mem_rframe_i (mem_rframe),
    .mem_rcount_i (mem_rcount),
    .res_space_i  (res_space),
    .res_load_o   (res_load),
    .res_ctl_o    (res_ctl),
    .res_slot_o   (res_slot),
    .res_frame_o  (res_frame),
    .res_count_o  (res_count)
  );

  // round up to the page: add page minus one, clear the offset bits
  assign round_sum = AW'(psize_q) + AW'(PAGE_BYTES - 1);
  assign map_addr  = {round_sum[AW-1:PageW], PageW'(0)};
  // slot index field keeps the low bits of the slot number
  assign slot_ext  = (IdxW + rcspt_pkg::SLOT_W)'(res_slot);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      psize_q <= req_i.process_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      status_q <= rcspt_pkg::ST_OK;
      slot_q   <= '0;
      frame_q  <= '0;
      taken_q  <= 1'b0;
      map_q    <= '0;
      nsize_q  <= '0;
      count_q  <= '0;
      freed_q  <= 1'b0;
    end else begin
      if (res_load) begin
        out_v_q  <= 1'b1;
        status_q <= res_ctl.status;
        slot_q   <= slot_ext[rcspt_pkg::SLOT_W-1:0];
        frame_q  <= res_frame;
        taken_q  <= res_ctl.taken;
        count_q  <= res_count;
        freed_q  <= res_ctl.freed;
        // map address only for a successful open
        if (res_ctl.is_open && res_ctl.status == rcspt_pkg::ST_OK) begin
          map_q   <= map_addr;
          nsize_q <= map_addr + AW'(PAGE_BYTES);
        end else begin
          map_q   <= '0;
          nsize_q <= '0;
        end
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid            = out_v_q;
  assign rsp_o.status           = status_q;
  assign rsp_o.slot_index       = slot_q;
  assign rsp_o.region_frame     = frame_q;
  assign rsp_o.frame_taken      = taken_q;
  assign rsp_o.map_address      = map_q;
  assign rsp_o.new_process_size = nsize_q;
  assign rsp_o.ref_count        = count_q;
  assign rsp_o.slot_freed       = freed_q;

  // an error result carries nothing but its status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && status_q != rcspt_pkg::ST_OK |->
      slot_q == '0 && frame_q == '0 && count_q == '0 && !taken_q && !freed_q &&
      map_q == '0 && nsize_q == '0)
    else $error("error result with non-zero fields");

  // a freshly claimed slot starts at a count of one, and a freed one ends at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && (taken_q || freed_q) |->
      status_q == rcspt_pkg::ST_OK && !(taken_q && freed_q) &&
      (taken_q ? count_q == COUNT_BITS'(1) : count_q == '0))
    else $error("claim or free with wrong count");

  // no memory read or write while the sequencer is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |-> !mem_ctl.wr_en && !mem_ctl.rd_en)
    else $error("slot memory accessed while idle");

  // the block is busy from acceptance until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("sequencer not busy after acceptance");

endmodule

// ----- dv/refcounted_shared_page_table_tb.sv -----
module refcounted_shared_page_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS   = rcspt_pkg::SLOT_COUNT_DEF;
  localparam int unsigned PAGE    = rcspt_pkg::PAGE_BYTES_DEF;
  localparam int unsigned FRAME_W = rcspt_pkg::FRAME_BITS_DEF;
  localparam int unsigned COUNT_W = rcspt_pkg::COUNT_BITS_DEF;
  localparam int unsigned ID_W    = rcspt_pkg::ID_W;
  localparam int unsigned PSIZE_W = rcspt_pkg::PSIZE_W;
  localparam int unsigned ADDR_W  = rcspt_pkg::ADDR_W;
  localparam int unsigned SLOT_W  = rcspt_pkg::SLOT_W;
  localparam int unsigned RANDOM_OPS   = 1600;
  localparam int unsigned REPEAT_OPENS = 100;
  localparam int unsigned ID_POOL      = 80;

  // one request item as the caller sees it
  typedef struct packed {
    rcspt_pkg::op_e     op;
    logic [ID_W-1:0]    id;
    logic [FRAME_W-1:0] frame;
    logic               frame_ok;
    logic [PSIZE_W-1:0] psize;
  } page_req_t;

  // one result item, field for field
  typedef struct packed {
    rcspt_pkg::status_e status;
    logic [SLOT_W-1:0]  slot;
    logic [FRAME_W-1:0] frame;
    logic               taken;
    logic [ADDR_W-1:0]  map_addr;
    logic [ADDR_W-1:0]  new_size;
    logic [COUNT_W-1:0] count;
    logic               freed;
  } page_rsp_t;

  logic clk_i;
  logic rst_ni;

  rcspt_req_if req_if ();
  rcspt_rsp_if rsp_if ();

  refcounted_shared_page_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the slot table, free after reset
  logic [ID_W-1:0]    key_mem   [SLOTS];
  logic [FRAME_W-1:0] frame_mem [SLOTS];
  logic [COUNT_W-1:0] count_mem [SLOTS];

  page_rsp_t pending_results[$];
  int        mismatch_count = 0;
  bit        idling = 1'b0;
  logic [ID_W-1:0] id_pool [ID_POOL];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // generous guard: far beyond the slowest legal run, full scans on every item
  initial begin
    #200ms;
    $display("TB_ERROR");
    $finish;
  end

  // works out the result of one accepted item and updates the shadow table
  function automatic page_rsp_t predict_page_op(input page_req_t r);
    page_rsp_t         res;
    int                hit;
    int                free_slot;
    logic [ADDR_W-1:0] rounded;
    res       = '0;
    hit       = -1;
    free_slot = -1;
    // walk downwards so the lowest matching and lowest free slot win
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (key_mem[i] == r.id) hit = i;
      if (key_mem[i] == '0) free_slot = i;
    end
    if (r.id == '0) begin
      res.status = rcspt_pkg::ST_BADID;
    end else if (r.op == rcspt_pkg::OP_OPEN) begin
      if (hit >= 0) begin
        // a hit only bumps the count, saturated counts are refused
        if (count_mem[hit] == '1) res.status = rcspt_pkg::ST_CNTFULL;
        else count_mem[hit] = count_mem[hit] + COUNT_W'(1);
      end else if (free_slot < 0) begin
        res.status = rcspt_pkg::ST_FULL;
      end else if (!r.frame_ok) begin
        // allocator out of memory, the free slot stays free
        res.status = rcspt_pkg::ST_NOFRAME;
      end else begin
        key_mem[free_slot]   = r.id;
        frame_mem[free_slot] = r.frame;
        count_mem[free_slot] = COUNT_W'(1);
        res.taken            = 1'b1;
        hit                  = free_slot;
      end
      if (res.status == rcspt_pkg::ST_OK) begin
        rounded      = (ADDR_W'({1'b0, r.psize}) + ADDR_W'(PAGE - 1)) & ~ADDR_W'(PAGE - 1);
        res.slot     = hit[SLOT_W-1:0];
        res.frame    = frame_mem[hit];
        res.count    = count_mem[hit];
        res.map_addr = rounded;
        res.new_size = rounded + ADDR_W'(PAGE);
      end
    end else begin
      if (hit < 0 || count_mem[hit] == '0) begin
        res.status = rcspt_pkg::ST_NOTOPEN;
      end else begin
        // frame is reported as held before any freeing
        res.slot       = hit[SLOT_W-1:0];
        res.frame      = frame_mem[hit];
        count_mem[hit] = count_mem[hit] - COUNT_W'(1);
        res.count      = count_mem[hit];
        if (count_mem[hit] == '0) begin
          key_mem[hit]   = '0;
          frame_mem[hit] = '0;
          res.freed      = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // drives one item and waits for its handshake; valid stays high between items unless idling
  task automatic send_page_op(input rcspt_pkg::op_e op, input logic [ID_W-1:0] id,
                              input logic [FRAME_W-1:0] frame, input logic frame_ok,
                              input logic [PSIZE_W-1:0] psize);
    page_req_t r;
    r = '{op, id, frame, frame_ok, psize};
    if (idling && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.op            <= op;
    req_if.region_id     <= id;
    req_if.offered_frame <= frame;
    req_if.offered_valid <= frame_ok;
    req_if.process_size  <= psize;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_results.push_back(predict_page_op(r));
  endtask

  task automatic open_region(input logic [ID_W-1:0] id, input logic [FRAME_W-1:0] frame,
                             input logic [PSIZE_W-1:0] psize);
    send_page_op(rcspt_pkg::OP_OPEN, id, frame, 1'b1, psize);
  endtask

  task automatic close_region(input logic [ID_W-1:0] id);
    send_page_op(rcspt_pkg::OP_CLOSE, id, FRAME_W'($urandom), 1'($urandom_range(0, 1)),
                 PSIZE_W'($urandom));
  endtask

  // zero ids, absent ids, no frame, field extremes, page rounding edges, slot reuse
  task automatic test_directed();
    idling = 1'b1;
    send_page_op(rcspt_pkg::OP_OPEN, '0, '1, 1'b1, '1);
    send_page_op(rcspt_pkg::OP_CLOSE, '0, '0, 1'b0, '0);
    close_region(32'h0000_0001);
    send_page_op(rcspt_pkg::OP_OPEN, 32'h0000_0001, 20'h12345, 1'b0, 31'd100);
    open_region(32'h0000_0001, '0, '0);
    open_region('1, '1, '1);
    open_region(32'h0000_0001, 20'h00001, 31'd1);
    open_region('1, 20'h0, 31'd4096);
    send_page_op(rcspt_pkg::OP_OPEN, '1, 20'h0, 1'b0, 31'd4097);
    close_region(32'h0000_0001);
    close_region(32'h0000_0001);
    close_region(32'h0000_0001);
    // slot 0 was freed above, so the next miss lands there again
    open_region(32'h8000_0000, 20'h5A5A5, 31'h4000_0FFF);
    open_region(32'h7FFF_FFFF, 20'hA5A5A, 31'h7FFF_F001);
    repeat (3) close_region('1);
    close_region(32'h8000_0000);
    close_region(32'h7FFF_FFFF);
  endtask

  // fill every slot, then misses must report a full table even without a frame
  task automatic test_table_full();
    idling = 1'b1;
    for (int i = 0; i < SLOTS; i++)
      open_region(32'h1000_0000 + i, FRAME_W'($urandom), PSIZE_W'($urandom));
    open_region(32'h2000_0000, 20'h11111, 31'd8192);
    send_page_op(rcspt_pkg::OP_OPEN, 32'h2000_0001, 20'h22222, 1'b0, 31'd8192);
    // hits still work while full
    open_region(32'h1000_0005, 20'h33333, 31'd10);
    repeat (2) close_region(32'h1000_0005);
    open_region(32'h2000_0000, 20'h44444, 31'd20);
    for (int i = 0; i < SLOTS; i++)
      if (i != 5) close_region(32'h1000_0000 + i);
    close_region(32'h2000_0000);
  endtask

  // stack up references on one region back to back; hits on slot 0 keep this quick
  task automatic test_repeated_open();
    idling = 1'b0;
    for (int i = 0; i < REPEAT_OPENS; i++)
      open_region(32'h0000_FACE, 20'h0F0F0, PSIZE_W'($urandom_range(0, 65535)));
    close_region(32'h0000_FACE);
    open_region(32'h0000_FACE, 20'h0F0F0, 31'd4095);
    open_region(32'h0000_FACE, 20'h0F0F0, 31'd4096);
    // the region stays mapped in slot 0 for the rest of the run
  endtask

  // mostly opens and closes from a small id pool so the table fills and drains,
  // with zero ids, stray ids and allocator failures mixed in
  task automatic test_random();
    int                 pick;
    logic [ID_W-1:0]    id;
    logic [PSIZE_W-1:0] psize;
    rcspt_pkg::op_e     op;
    for (int i = 0; i < ID_POOL; i++) begin
      id_pool[i] = $urandom;
      if (id_pool[i] == '0) id_pool[i] = 32'h0000_0002;
    end
    for (int n = 0; n < RANDOM_OPS; n++) begin
      // final quarter runs without idling on either side
      idling = (n < RANDOM_OPS * 3 / 4);
      pick   = $urandom_range(0, 99);
      op     = (pick < 55) ? rcspt_pkg::OP_OPEN : rcspt_pkg::OP_CLOSE;
      id     = id_pool[$urandom_range(0, ID_POOL - 1)];
      if (pick >= 90 && pick < 95) begin
        id = '0;
        op = rcspt_pkg::op_e'($urandom_range(0, 1));
      end else if (pick >= 95) begin
        id = $urandom;
        op = rcspt_pkg::op_e'($urandom_range(0, 1));
      end
      psize = ($urandom_range(0, 1) == 0) ? PSIZE_W'($urandom_range(0, 20000))
                                          : PSIZE_W'($urandom);
      send_page_op(op, id, FRAME_W'($urandom), $urandom_range(0, 9) != 0, psize);
    end
  endtask

  task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                               input logic [ADDR_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // result side: bursts of back-pressure while idling is on
  initial begin
    rsp_if.ready <= 1'b1;
    @(posedge clk_i);
    forever begin
      if (idling && $urandom_range(0, 3) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // every accepted result item is matched against the oldest prediction
  always @(posedge clk_i) begin
    page_rsp_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result item with no operation outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", ADDR_W'(want.status), ADDR_W'(rsp_if.status));
        compare_field("slot_index", ADDR_W'(want.slot), ADDR_W'(rsp_if.slot_index));
        compare_field("region_frame", ADDR_W'(want.frame), ADDR_W'(rsp_if.region_frame));
        compare_field("frame_taken", ADDR_W'(want.taken), ADDR_W'(rsp_if.frame_taken));
        compare_field("map_address", want.map_addr, rsp_if.map_address);
        compare_field("new_process_size", want.new_size, rsp_if.new_process_size);
        compare_field("ref_count", ADDR_W'(want.count), ADDR_W'(rsp_if.ref_count));
        compare_field("slot_freed", ADDR_W'(want.freed), ADDR_W'(rsp_if.slot_freed));
      end
    end
  end

  initial begin
    int guard;
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.op            <= rcspt_pkg::OP_OPEN;
    req_if.region_id     <= '0;
    req_if.offered_frame <= '0;
    req_if.offered_valid <= 1'b0;
    req_if.process_size  <= '0;
    for (int i = 0; i < SLOTS; i++) begin
      key_mem[i]   = '0;
      frame_mem[i] = '0;
      count_mem[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_table_full();
    test_repeated_open();
    test_random();

    req_if.valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // a full scan plus output register before calling it done
    repeat (80) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
